// ----- rtl/core/rtsu_pkg.sv -----
// ----------------------------------------------------------------------------
// rtsu_pkg
// Shared constants and types for the text screen run-length unpacker.
// ----------------------------------------------------------------------------
package rtsu_pkg;

	localparam int ADDR_W = 12;
	localparam int DATA_W = 8;
	localparam int CNT_W  = 6;

	localparam logic [ADDR_W-1:0] SCREEN_BYTES = 12'd4000;
	localparam logic [1:0]        RUN_MARK     = 2'b11;

	// command queue between front and back
	localparam int CMDQ_DEPTH = 4;
	localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
	localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

	// one run to be written: a literal is a run of one
	typedef struct packed {
		logic [CNT_W-1:0]  count;
		logic [DATA_W-1:0] data;
	} cmd_t;

endpackage

// ----- rtl/core/rle_text_screen_unpacker.sv -----
// ----------------------------------------------------------------------------
// rle_text_screen_unpacker
// Run-length decoder for a text screen image: compressed bytes in, screen
// writes (address, data) out.
// ----------------------------------------------------------------------------
// Usage:
//   Input queue: drive code_byte with push; a byte is taken on a clock edge
//   with push high and full low. Bytes follow the file header.
//   Output queue: while empty is low, write_addr/write_data/run_end/overflow
//   hold the oldest write; pop high with empty low takes it.
//   A count byte (top two bits set) repeats the next byte count times; any
//   other byte is written once. Characters fill even addresses, then
//   attributes fill odd ones; writes past the screen come out with overflow
//   set and must be dropped by the consumer.
// Path: a literal goes through the command queue, the writer's run register and the output register.
// Throughput: the writer issues one screen write per cycle while the output
//   is not stalled, so a literal gives one write and a run of n gives n writes;
//   count bytes and zero-count runs give no write. A four-entry command queue
//   lets the input keep taking bytes while a run is expanded.
// Reset: arst_n clears the queues, the count state and sets the character
//   address to 0 and the attribute address to 1.
// Stall: with pop low the output register holds; the writer stops, the
//   command queue fills and full rises.
// ----------------------------------------------------------------------------
module rle_text_screen_unpacker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	output logic                        full,
	input  logic [rtsu_pkg::DATA_W-1:0] code_byte,
	output logic                        empty,
	input  logic                        pop,
	output logic [rtsu_pkg::ADDR_W-1:0] write_addr,
	output logic [rtsu_pkg::DATA_W-1:0] write_data,
	output logic                        run_end,
	output logic                        overflow
);

	logic                                accept;
	logic                                cmd_push;
	rtsu_pkg::cmd_t                      cmd;
	rtsu_pkg::cmd_t                      head_cmd;
	logic                                q_full;
	logic                                q_empty;
	logic                                q_pop;
	logic [rtsu_pkg::CMDQ_CNT_W-1:0]     q_level;
	logic                                out_valid;
	logic                                back_busy;
	logic [rtsu_pkg::CNT_W-1:0]          back_remain;

	assign full   = q_full;
	assign accept = push && !q_full;
	assign empty  = !out_valid;

	rtsu_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.code_byte (code_byte),
		.cmd_push  (cmd_push),
		.cmd       (cmd)
	);

	rtsu_cmdq u_cmdq (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (cmd_push),
		.push_cmd (cmd),
		.pop      (q_pop),
		.head_cmd (head_cmd),
		.q_full   (q_full),
		.q_empty  (q_empty),
		.level    (q_level)
	);

	rtsu_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_empty    (q_empty),
		.head_cmd   (head_cmd),
		.q_pop      (q_pop),
		.out_valid  (out_valid),
		.out_take   (pop),
		.write_addr (write_addr),
		.write_data (write_data),
		.run_end    (run_end),
		.overflow   (overflow),
		.busy       (back_busy),
		.remain     (back_remain)
	);

`ifndef SYNTHESIS
	a_q_level: assert property (@(posedge clk) disable iff (!arst_n)
		q_level <= rtsu_pkg::CMDQ_CNT_W'(rtsu_pkg::CMDQ_DEPTH))
		else $error("command queue level beyond depth");

	a_busy_remain: assert property (@(posedge clk) disable iff (!arst_n)
		back_busy |-> (back_remain != '0))
		else $error("writer busy with no writes left");

	a_ovf_addr: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (overflow == (write_addr >= rtsu_pkg::SCREEN_BYTES)))
		else $error("overflow flag disagrees with address");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(write_addr) && $stable(run_end)))
		else $error("waiting write changed under stall");
`endif

endmodule

// ----- rtl/core/rtsu_front.sv -----
// ----------------------------------------------------------------------------
// rtsu_front
// Classifies incoming code bytes into literal, count and value bytes and
// turns them into run commands.
// ----------------------------------------------------------------------------
module rtsu_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        accept,
	input  logic [rtsu_pkg::DATA_W-1:0] code_byte,
	output logic                        cmd_push,
	output rtsu_pkg::cmd_t              cmd
);

	logic                       await_q;
	logic [rtsu_pkg::CNT_W-1:0] pending_q;
	logic                       is_count;

	assign is_count = (code_byte[rtsu_pkg::DATA_W-1 -: 2] == rtsu_pkg::RUN_MARK);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			await_q   <= 1'b0;
			pending_q <= '0;
		end else if (accept) begin
			if (await_q) begin
				await_q <= 1'b0;
			end else if (is_count) begin
				await_q   <= 1'b1;
				pending_q <= code_byte[rtsu_pkg::CNT_W-1:0];
			end
		end
	end

	// a zero count swallows its value byte without a command
	always_comb begin
		cmd.data = code_byte;
		if (await_q) begin
			cmd.count = pending_q;
			cmd_push  = accept && (pending_q != '0);
		end else begin
			cmd.count = rtsu_pkg::CNT_W'(1);
			cmd_push  = accept && !is_count;
		end
	end

endmodule

// ----- rtl/core/rtsu_cmdq.sv -----
// ----------------------------------------------------------------------------
// rtsu_cmdq
// Small FIFO of run commands decoupling the byte classifier from the writer.
// ----------------------------------------------------------------------------
module rtsu_cmdq (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                push,
	input  rtsu_pkg::cmd_t                      push_cmd,
	input  logic                                pop,
	output rtsu_pkg::cmd_t                      head_cmd,
	output logic                                q_full,
	output logic                                q_empty,
	output logic [rtsu_pkg::CMDQ_CNT_W-1:0]     level
);

	rtsu_pkg::cmd_t                      slot_q [rtsu_pkg::CMDQ_DEPTH];
	logic [rtsu_pkg::CMDQ_PTR_W-1:0]     wr_ptr_q;
	logic [rtsu_pkg::CMDQ_PTR_W-1:0]     rd_ptr_q;
	logic [rtsu_pkg::CMDQ_CNT_W-1:0]     cnt_q;
	logic                                do_push;
	logic                                do_pop;

	assign q_full   = (cnt_q == rtsu_pkg::CMDQ_CNT_W'(rtsu_pkg::CMDQ_DEPTH));
	assign q_empty  = (cnt_q == '0);
	assign level    = cnt_q;
	assign head_cmd = slot_q[rd_ptr_q];
	assign do_push  = push && !q_full;
	assign do_pop   = pop && !q_empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			// level holds when both or neither happen
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ----- rtl/core/rtsu_back.sv -----
// ----------------------------------------------------------------------------
// rtsu_back
// Expands run commands into screen writes, one per cycle while the output is
// not stalled, and steps the character and attribute address counters.
// ----------------------------------------------------------------------------
module rtsu_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        q_empty,
	input  rtsu_pkg::cmd_t              head_cmd,
	output logic                        q_pop,
	output logic                        out_valid,
	input  logic                        out_take,
	output logic [rtsu_pkg::ADDR_W-1:0] write_addr,
	output logic [rtsu_pkg::DATA_W-1:0] write_data,
	output logic                        run_end,
	output logic                        overflow,
	output logic                        busy,
	output logic [rtsu_pkg::CNT_W-1:0]  remain
);

	logic                        busy_q;
	logic [rtsu_pkg::CNT_W-1:0]  remain_q;
	logic [rtsu_pkg::DATA_W-1:0] data_q;
	logic [rtsu_pkg::ADDR_W-1:0] char_addr_q;
	logic [rtsu_pkg::ADDR_W-1:0] attr_addr_q;
	logic                        out_valid_q;
	logic [rtsu_pkg::ADDR_W-1:0] addr_out_q;
	logic [rtsu_pkg::DATA_W-1:0] data_out_q;
	logic                        end_out_q;
	logic                        ovf_out_q;

	logic                        emit;
	logic                        last;
	logic                        char_ok;
	logic                        attr_ok;

	assign emit    = busy_q && (!out_valid_q || out_take);
	assign last    = (remain_q == rtsu_pkg::CNT_W'(1));
	// next command loads as the current one finishes
	assign q_pop   = !q_empty && (!busy_q || (emit && last));
	assign char_ok = (char_addr_q < rtsu_pkg::SCREEN_BYTES);
	assign attr_ok = (attr_addr_q < rtsu_pkg::SCREEN_BYTES);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			remain_q    <= '0;
			char_addr_q <= '0;
			attr_addr_q <= rtsu_pkg::ADDR_W'(1);
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				busy_q   <= 1'b1;
				remain_q <= head_cmd.count;
			end else if (emit) begin
				remain_q <= remain_q - 1'b1;
				if (last) begin
					busy_q <= 1'b0;
				end
			end
			if (emit) begin
				// attribute address saturates once past the screen
				priority if (char_ok) begin
					char_addr_q <= char_addr_q + rtsu_pkg::ADDR_W'(2);
				end else if (attr_ok) begin
					attr_addr_q <= attr_addr_q + rtsu_pkg::ADDR_W'(2);
				end else begin
					attr_addr_q <= attr_addr_q;
				end
				out_valid_q <= 1'b1;
			end else if (out_take) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			data_q <= head_cmd.data;
		end
		if (emit) begin
			addr_out_q <= char_ok ? char_addr_q : attr_addr_q;
			data_out_q <= data_q;
			end_out_q  <= last;
			ovf_out_q  <= !char_ok && !attr_ok;
		end
	end

	assign out_valid  = out_valid_q;
	assign write_addr = addr_out_q;
	assign write_data = data_out_q;
	assign run_end    = end_out_q;
	assign overflow   = ovf_out_q;
	assign busy       = busy_q;
	assign remain     = remain_q;

endmodule
